/* rtl/region_permission_checker_defines.svh */
// Assertion macros shared by the region permission checker RTL.
`ifndef REGION_PERMISSION_CHECKER_DEFINES_SVH
`define REGION_PERMISSION_CHECKER_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define RPC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define RPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/rpc_pkg.sv */
// Types and constants for the region permission checker.
package rpc_pkg;

  localparam int REGION_COUNT = 16;
  localparam int IDX_W = (REGION_COUNT > 1) ? $clog2(REGION_COUNT) : 1;
  localparam int CFG_IDX_W = 2;
  localparam logic [4:0] LEAK_MAX = 5'd31;

  typedef enum logic [2:0] {
    MODE_GRANT  = 3'd0,
    MODE_REVOKE = 3'd1,
    MODE_CHECK  = 3'd2,
    MODE_FIND   = 3'd3,
    MODE_LEAK   = 3'd4
  } mode_t;

  typedef enum logic [3:0] {
    ST_OK          = 4'd0,
    ST_BAD_SIZE    = 4'd1,
    ST_OVERLAP     = 4'd2,
    ST_NOT_MAPPED  = 4'd3,
    ST_PAST_END    = 4'd4,
    ST_WRONG_START = 4'd5,
    ST_NO_PERM     = 4'd6,
    ST_FULL        = 4'd7,
    ST_LEAKS       = 4'd8
  } status_t;

  localparam logic [CFG_IDX_W-1:0] CFG_CHECK_ERRORS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHECK_LEAKS  = 2'd1;

  typedef struct packed {
    logic [2:0]  mode;
    logic [63:0] start_address;
    logic [63:0] length;
    logic [1:0]  access_perms;
    logic [63:0] region_id;
    logic        permanent;
    logic        size_any;
    logic        perms_any;
    logic        id_any;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [63:0] region_base;
    logic [63:0] region_length;
    logic        size_mismatch;
    logic        perms_mismatch;
    logic        id_mismatch;
    logic [4:0]  leak_count;
  } out_item_t;

  // One stored region record.
  typedef struct packed {
    logic [63:0] base;
    logic [63:0] length;
    logic [1:0]  perms;
    logic [63:0] ident;
    logic        keep;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

/* rtl/rpc_in_if.sv */
// Request channel interface of the region permission checker.
interface rpc_in_if
  import rpc_pkg::*;
;
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/rpc_out_if.sv */
// Result channel interface of the region permission checker.
interface rpc_out_if
  import rpc_pkg::*;
;
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/region_permission_checker.sv */
// Region permission checker: a table of REGION_COUNT non-overlapping address
// regions held in one synchronous RAM, with valid bits in flip-flops. Each
// request transaction (grant, revoke, check, find, leak check) is handled by
// one sweep that reads every table entry in turn through the RAM read port
// and evaluates each entry from the registered read data; the result then
// goes into the output register, which holds it until the sink takes it.
// A new request is accepted once the previous result has been moved into
// the output register. Table updates are written back at the end of the
// sweep, so no read can see a stale entry. No clearing pass is needed
// after reset.
`include "region_permission_checker_defines.svh"

module region_permission_checker
  import rpc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  rpc_in_if.sink               in_ch,
  rpc_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic                 cfg_wdata
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_t;

  state_t            state_r;
  in_item_t          req_r;
  logic              wraps_r;
  logic              cee_r, cle_r;
  logic [REGION_COUNT-1:0] valid_r;
  logic [IDX_W:0]    issue_cnt_r;
  logic              dv_r;
  logic [IDX_W-1:0]  dv_idx_r;
  logic              found_r;
  logic [IDX_W-1:0]  hit_idx_r;
  entry_t            hit_r;
  logic              free_found_r;
  logic [IDX_W-1:0]  free_idx_r;
  logic [4:0]        leak_cnt_r;
  logic              out_valid_r;
  out_item_t         out_data_r;

  logic              issuing;
  logic              rd_en;
  logic [ENTRY_W-1:0] rd_word;
  entry_t            rd_entry;
  logic              cur_valid;
  logic              is_holder, is_overlap, is_match;
  logic              wr_en;
  entry_t            wr_entry;
  out_item_t         res;
  logic              clear_en;
  logic              fire;

  assign in_ch.ready  = (state_r == S_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  // Entry storage.
  rpc_ram #(.WIDTH(ENTRY_W), .DEPTH(REGION_COUNT)) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (free_idx_r),
    .wr_data (wr_entry),
    .rd_en   (rd_en),
    .rd_addr (issue_cnt_r[IDX_W-1:0]),
    .rd_data (rd_word)
  );

  // Read issue and per-entry match evaluation.
  always_comb begin
    issuing    = (issue_cnt_r < (IDX_W+1)'(REGION_COUNT));
    rd_en      = (state_r == S_SCAN) && issuing;
    rd_entry   = entry_t'(rd_word);
    cur_valid  = valid_r[dv_idx_r];
    is_holder  = cur_valid && (req_r.start_address >= rd_entry.base) &&
                 ((req_r.start_address - rd_entry.base) < rd_entry.length);
    is_overlap = cur_valid &&
                 (req_r.start_address < (rd_entry.base + rd_entry.length)) &&
                 (rd_entry.base < (req_r.start_address + req_r.length));
    is_match   = (req_r.mode == MODE_GRANT) ? is_overlap : is_holder;
  end

  // Result and table update at the end of the sweep.
  always_comb begin
    res      = '0;
    res.status = ST_OK;
    wr_en    = 1'b0;
    clear_en = 1'b0;
    wr_entry.base   = req_r.start_address;
    wr_entry.length = req_r.length;
    wr_entry.perms  = req_r.access_perms;
    wr_entry.ident  = req_r.region_id;
    wr_entry.keep   = req_r.permanent;
    fire = (state_r == S_FINISH) && (!out_valid_r || out_ch.ready);
    unique case (req_r.mode)
      MODE_GRANT: begin
        if (req_r.length == '0 || wraps_r) begin
          res.status = ST_BAD_SIZE;
        end else if (found_r) begin
          res.status        = ST_OVERLAP;
          res.region_base   = hit_r.base;
          res.region_length = hit_r.length;
        end else if (!free_found_r) begin
          res.status = ST_FULL;
        end else begin
          res.region_base   = req_r.start_address;
          res.region_length = req_r.length;
          wr_en             = fire;
        end
      end
      MODE_REVOKE: begin
        if (!req_r.size_any && wraps_r) begin
          res.status = ST_BAD_SIZE;
        end else if (!found_r) begin
          res.status = ST_NOT_MAPPED;
        end else begin
          res.region_base   = hit_r.base;
          res.region_length = hit_r.length;
          if (hit_r.base != req_r.start_address) begin
            res.status = ST_WRONG_START;
          end else begin
            res.size_mismatch  = !req_r.size_any && (hit_r.length != req_r.length);
            res.perms_mismatch = !req_r.perms_any && (hit_r.perms != req_r.access_perms);
            res.id_mismatch    = !req_r.id_any && (hit_r.ident != req_r.region_id);
            clear_en           = fire;
          end
        end
      end
      MODE_CHECK: begin
        if (cee_r) begin
          if (wraps_r) begin
            res.status = ST_BAD_SIZE;
          end else if (!found_r) begin
            res.status = ST_NOT_MAPPED;
          end else begin
            res.region_base   = hit_r.base;
            res.region_length = hit_r.length;
            if ((hit_r.base + hit_r.length) < (req_r.start_address + req_r.length)) begin
              res.status = ST_PAST_END;
            end else if ((req_r.access_perms & hit_r.perms) != req_r.access_perms) begin
              res.status = ST_NO_PERM;
            end
          end
        end
      end
      MODE_FIND: begin
        if (found_r) begin
          res.region_base   = hit_r.base;
          res.region_length = hit_r.length;
        end else begin
          res.status = ST_NOT_MAPPED;
        end
      end
      MODE_LEAK: begin
        if (cle_r) begin
          res.leak_count = leak_cnt_r;
          if (leak_cnt_r != '0) begin
            res.status = ST_LEAKS;
          end
        end
      end
      default: begin
        res.status = ST_OK;
      end
    endcase
  end

  // Sequencer, table valid bits, configuration and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cee_r       <= 1'b1;
      cle_r       <= 1'b1;
      valid_r     <= '0;
      dv_r        <= 1'b0;
      out_valid_r <= 1'b0;
      issue_cnt_r <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_CHECK_ERRORS) begin
          cee_r <= cfg_wdata;
        end else if (cfg_index == CFG_CHECK_LEAKS) begin
          cle_r <= cfg_wdata;
        end
      end
      // The output register fills on a finished sweep and empties when taken.
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      dv_r <= rd_en;
      if (rd_en) begin
        dv_idx_r    <= issue_cnt_r[IDX_W-1:0];
        issue_cnt_r <= issue_cnt_r + 1'b1;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            req_r        <= in_ch.data;
            wraps_r      <= (in_ch.data.start_address + in_ch.data.length) <
                            in_ch.data.start_address;
            issue_cnt_r  <= '0;
            found_r      <= 1'b0;
            free_found_r <= 1'b0;
            leak_cnt_r   <= '0;
            state_r      <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (dv_r) begin
            if (is_match && !found_r) begin
              found_r   <= 1'b1;
              hit_idx_r <= dv_idx_r;
              hit_r     <= rd_entry;
            end
            if (!cur_valid && !free_found_r) begin
              free_found_r <= 1'b1;
              free_idx_r   <= dv_idx_r;
            end
            if (cur_valid && !rd_entry.keep && leak_cnt_r != LEAK_MAX) begin
              leak_cnt_r <= leak_cnt_r + 1'b1;
            end
            if (dv_idx_r == IDX_W'(REGION_COUNT - 1)) begin
              state_r <= S_FINISH;
            end
          end
        end
        S_FINISH: begin
          if (fire) begin
            out_data_r  <= res;
            if (wr_en) begin
              valid_r[free_idx_r] <= 1'b1;
            end
            if (clear_en) begin
              valid_r[hit_idx_r] <= 1'b0;
            end
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  `RPC_ASSERT_NEXT(a_one_at_a_time, in_ch.valid && in_ch.ready, !in_ch.ready, "request accepted while busy")
  `RPC_ASSERT_NEXT(a_grant_sets_valid, wr_en, valid_r[$past(free_idx_r)], "granted entry not marked valid")
  `RPC_ASSERT_NOW(a_leak_status, out_valid_r && out_data_r.leak_count != '0, out_data_r.status == ST_LEAKS, "leak count without leak status")

endmodule

/* rtl/rpc_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module rpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule
